// File: hw/rtl/ppm_pkg.sv
// ----------------------------------------------------------------------------
// ppm_pkg: shared types and constants of the perspective point mapper
// Point and result formats, coefficient indexes and arithmetic constants.
// ----------------------------------------------------------------------------
package ppm_pkg;

	localparam int PIX_W     = 12;
	localparam int COEF_W    = 48;
	localparam int ACC_W     = 64;
	localparam int ROOM_X_W  = 9;
	localparam int ROOM_Y_W  = 10;
	localparam int NUM_COEF  = 8;
	localparam int IDX_W     = 3;
	localparam int LANES     = 2;
	localparam int LANE_X    = 0;
	localparam int LANE_Y    = 1;

	localparam int ROOM_WIDTH_DEF  = 5000;
	localparam int ROOM_LENGTH_DEF = 7500;
	localparam int COORD_BITS_DEF  = 12;

	// 1.0 in Q16.32
	localparam logic [COEF_W-1:0] COEF_ONE = 48'h0001_0000_0000;
	localparam logic [ACC_W-1:0]  ACC_ONE  = 64'h0000_0001_0000_0000;

	// n / 10 == (n * 0xCCCD) >> 19 for every n below 81920
	localparam int             RECIP_W   = 16;
	localparam logic [RECIP_W-1:0] RECIP10 = 16'hCCCD;
	localparam int             RECIP_SH  = 19;
	localparam int             PROD_W    = 32;

	typedef enum logic [IDX_W-1:0] {
		COEF_00 = 3'd0,
		COEF_01 = 3'd1,
		COEF_02 = 3'd2,
		COEF_10 = 3'd3,
		COEF_11 = 3'd4,
		COEF_12 = 3'd5,
		COEF_20 = 3'd6,
		COEF_21 = 3'd7
	} coef_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0] pix_x;
		logic [PIX_W-1:0] pix_y;
	} in_item_t;

	typedef struct packed {
		logic [ROOM_X_W-1:0] room_x;
		logic [ROOM_Y_W-1:0] room_y;
		logic                degenerate;
	} out_item_t;

	// sideband that rides along the divider
	typedef struct packed {
		logic             degen;
		logic [LANES-1:0] neg;
	} tag_t;

endpackage

// File: hw/rtl/ppm_div.sv
// ----------------------------------------------------------------------------
// ppm_div: pipelined unsigned divider with saturation
// Restoring division, one quotient bit per stage, denominator shared by
// all lanes. A quotient of 2^QW or more is flagged as saturated.
// ----------------------------------------------------------------------------
module ppm_div #(
	parameter int QW = 13
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_vld,
	input  ppm_pkg::tag_t                              in_tag,
	input  logic [ppm_pkg::LANES-1:0][ppm_pkg::ACC_W-1:0] in_num,
	input  logic [ppm_pkg::ACC_W-1:0]                  in_den,
	output logic                                       out_vld,
	output ppm_pkg::tag_t                              out_tag,
	output logic [ppm_pkg::LANES-1:0][QW-1:0]          out_quo,
	output logic [ppm_pkg::LANES-1:0]                  out_sat
);

	localparam int AW    = ppm_pkg::ACC_W;
	localparam int NL    = ppm_pkg::LANES;
	localparam int EXT_W = AW + QW;

	logic                         vld_s [QW+1];
	ppm_pkg::tag_t                tag_s [QW+1];
	logic [NL-1:0][AW-1:0]        rem_s [QW+1];
	logic [AW-1:0]                den_s [QW+1];
	logic [NL-1:0][QW-1:0]        quo_s [QW+1];
	logic [NL-1:0]                sat_s [QW+1];

	logic [EXT_W-1:0] den_top;
	assign den_top = {{QW{1'b0}}, in_den} << QW;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		tag_s[0] <= in_tag;
		rem_s[0] <= in_num;
		den_s[0] <= in_den;
		quo_s[0] <= '0;
		for (int l = 0; l < NL; l++) begin
			sat_s[0][l] <= ({{QW{1'b0}}, in_num[l]} >= den_top);
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		localparam int B = QW - 1 - k;

		logic [EXT_W-1:0]      dsh;
		logic [NL-1:0]         ge;
		logic [NL-1:0][AW-1:0] rem_nx;
		logic [NL-1:0][QW-1:0] quo_nx;

		assign dsh = {{QW{1'b0}}, den_s[k]} << B;

		always_comb begin
			for (int l = 0; l < NL; l++) begin
				ge[l]        = ({{QW{1'b0}}, rem_s[k][l]} >= dsh);
				rem_nx[l]    = ge[l] ? (rem_s[k][l] - dsh[AW-1:0]) : rem_s[k][l];
				quo_nx[l]    = quo_s[k][l];
				quo_nx[l][B] = ge[l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			tag_s[k+1] <= tag_s[k];
			rem_s[k+1] <= rem_nx;
			den_s[k+1] <= den_s[k];
			quo_s[k+1] <= quo_nx;
			sat_s[k+1] <= sat_s[k];
		end
	end

	assign out_vld = vld_s[QW];
	assign out_tag = tag_s[QW];
	assign out_quo = quo_s[QW];
	assign out_sat = sat_s[QW];

endmodule

// File: hw/rtl/perspective_point_mapper.sv
// ----------------------------------------------------------------------------
// perspective_point_mapper: image point to room grid through a 3x3 homography
// Multiplies, sums, divides both numerators by the denominator, clamps to the
// room and scales by one tenth.
// ----------------------------------------------------------------------------
// Divider width: QW = clog2(max room bound + 1); the divider resolves one bit per stage.
// Throughput: one point per cycle; busy stays low, done cannot be held off.
// Reset: clears all valid bits and loads the identity coefficients.
module perspective_point_mapper #(
	parameter int ROOM_WIDTH  = ppm_pkg::ROOM_WIDTH_DEF,
	parameter int ROOM_LENGTH = ppm_pkg::ROOM_LENGTH_DEF,
	parameter int COORD_BITS  = ppm_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  ppm_pkg::in_item_t           point,
	output logic                        done,
	output ppm_pkg::out_item_t          result,
	input  logic                        wr_en,
	input  logic [ppm_pkg::IDX_W-1:0]   wr_index,
	input  logic [ppm_pkg::COEF_W-1:0]  wr_data
);

	localparam int AW       = ppm_pkg::ACC_W;
	localparam int CW       = ppm_pkg::COEF_W;
	localparam int NL       = ppm_pkg::LANES;
	localparam int XW       = (COORD_BITS < ppm_pkg::PIX_W) ? COORD_BITS : ppm_pkg::PIX_W;
	localparam int ROOM_MAX = (ROOM_WIDTH > ROOM_LENGTH) ? ROOM_WIDTH : ROOM_LENGTH;
	localparam int QW       = $clog2(ROOM_MAX + 1);
	localparam int LAT      = QW + 6;
	localparam logic [QW-1:0] HI_X = QW'(ROOM_WIDTH);
	localparam logic [QW-1:0] HI_Y = QW'(ROOM_LENGTH);

	// signed coefficient times unsigned pixel, exact, then sign-extended
	function automatic logic [AW-1:0] mul_coef(input logic signed [CW-1:0] c,
	                                           input logic [XW-1:0] p);
		logic signed [XW:0]    pe;
		logic signed [CW+XW:0] prod;
		pe   = $signed({1'b0, p});
		prod = c * pe;
		return AW'(prod);
	endfunction

	// coefficient registers
	logic signed [CW-1:0] coef_q [ppm_pkg::NUM_COEF];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ppm_pkg::NUM_COEF; i++) begin
				coef_q[i] <= '0;
			end
			coef_q[ppm_pkg::COEF_00] <= ppm_pkg::COEF_ONE;
			coef_q[ppm_pkg::COEF_11] <= ppm_pkg::COEF_ONE;
		end else if (wr_en) begin
			coef_q[wr_index] <= wr_data;
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// s1: products
	logic          vld_s1;
	logic [AW-1:0] px0_s1, py0_s1, px1_s1, py1_s1, px2_s1, py2_s1;
	logic [XW-1:0] xin, yin;

	assign xin = point.pix_x[XW-1:0];
	assign yin = point.pix_y[XW-1:0];

	// s2: numerators and denominator
	logic          vld_s2;
	logic [AW-1:0] nx_s2, ny_s2, d_s2;

	// s3: magnitudes and signs
	logic                  vld_s3;
	logic [NL-1:0][AW-1:0] mag_n_s3;
	logic [AW-1:0]         mag_d_s3;
	ppm_pkg::tag_t         tag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		px0_s1 <= mul_coef(coef_q[ppm_pkg::COEF_00], xin);
		py0_s1 <= mul_coef(coef_q[ppm_pkg::COEF_01], yin);
		px1_s1 <= mul_coef(coef_q[ppm_pkg::COEF_10], xin);
		py1_s1 <= mul_coef(coef_q[ppm_pkg::COEF_11], yin);
		px2_s1 <= mul_coef(coef_q[ppm_pkg::COEF_20], xin);
		py2_s1 <= mul_coef(coef_q[ppm_pkg::COEF_21], yin);

		nx_s2 <= px0_s1 + py0_s1 + AW'(coef_q[ppm_pkg::COEF_02]);
		ny_s2 <= px1_s1 + py1_s1 + AW'(coef_q[ppm_pkg::COEF_12]);
		d_s2  <= px2_s1 + py2_s1 + ppm_pkg::ACC_ONE;

		mag_n_s3[ppm_pkg::LANE_X] <= nx_s2[AW-1] ? -nx_s2 : nx_s2;
		mag_n_s3[ppm_pkg::LANE_Y] <= ny_s2[AW-1] ? -ny_s2 : ny_s2;
		mag_d_s3                  <= d_s2[AW-1] ? -d_s2 : d_s2;
		tag_s3.degen              <= (d_s2 == '0);
		// opposite signs give a quotient at or below zero
		tag_s3.neg[ppm_pkg::LANE_X] <= nx_s2[AW-1] ^ d_s2[AW-1];
		tag_s3.neg[ppm_pkg::LANE_Y] <= ny_s2[AW-1] ^ d_s2[AW-1];
	end

	// divider
	logic                  div_vld;
	ppm_pkg::tag_t         div_tag;
	logic [NL-1:0][QW-1:0] div_quo;
	logic [NL-1:0]         div_sat;

	ppm_div #(
		.QW (QW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s3),
		.in_tag  (tag_s3),
		.in_num  (mag_n_s3),
		.in_den  (mag_d_s3),
		.out_vld (div_vld),
		.out_tag (div_tag),
		.out_quo (div_quo),
		.out_sat (div_sat)
	);

	// s4: clamp to the room, s5: scale by one tenth
	logic                  vld_s4;
	logic                  degen_s4;
	logic [NL-1:0][QW-1:0] lim_s4;
	logic [NL-1:0][QW-1:0] lim_nx;
	logic [QW-1:0]         hi [NL];

	logic                       vld_s5;
	ppm_pkg::out_item_t         res_s5;
	logic [ppm_pkg::PROD_W-1:0] rx, ry;

	assign hi[ppm_pkg::LANE_X] = HI_X;
	assign hi[ppm_pkg::LANE_Y] = HI_Y;

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			if (div_tag.degen || div_tag.neg[l]) begin
				lim_nx[l] = '0;
			end else if (div_sat[l] || (div_quo[l] > hi[l])) begin
				lim_nx[l] = hi[l];
			end else begin
				lim_nx[l] = div_quo[l];
			end
		end
	end

	assign rx = ppm_pkg::PROD_W'(lim_s4[ppm_pkg::LANE_X]) * ppm_pkg::PROD_W'(ppm_pkg::RECIP10);
	assign ry = ppm_pkg::PROD_W'(lim_s4[ppm_pkg::LANE_Y]) * ppm_pkg::PROD_W'(ppm_pkg::RECIP10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s4 <= div_vld;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		lim_s4            <= lim_nx;
		degen_s4          <= div_tag.degen;
		res_s5.room_x     <= rx[ppm_pkg::RECIP_SH +: ppm_pkg::ROOM_X_W];
		res_s5.room_y     <= ry[ppm_pkg::RECIP_SH +: ppm_pkg::ROOM_Y_W];
		res_s5.degenerate <= degen_s4;
	end

	assign done   = vld_s5;
	assign result = res_s5;

`ifndef SYNTH
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("request did not complete after the pipeline latency");

	a_latency_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("done without a matching request");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.degenerate) |-> (result.room_x == '0 && result.room_y == '0))
		else $error("degenerate result with nonzero coordinates");

	a_room_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (int'(result.room_x) <= ROOM_WIDTH / 10 &&
		          int'(result.room_y) <= ROOM_LENGTH / 10))
		else $error("room coordinate beyond the room bound");
`endif

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the perspective point mapper
// Loads coefficient matrices and sends image points, idling between requests at
// random. An in-bench mapping of each request predicts its room cell, and
// every done strobe is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ppm_pkg::*;

	localparam int  RAND_PHASES   = 10;
	localparam int  PHASE_POINTS  = 100;
	localparam int  SETTLE_CYCLES = 40;
	localparam int  CYCLE_LIMIT   = 200000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	in_item_t            point = '0;
	logic                done;
	out_item_t           result;
	logic                wr_en = 1'b0;
	logic [IDX_W-1:0]    wr_index = '0;
	logic [COEF_W-1:0]   wr_data = '0;

	logic [COEF_W-1:0]   coef_q [NUM_COEF];
	logic [COEF_W-1:0]   staged_coef [NUM_COEF];
	out_item_t           pending_rooms [$];
	int unsigned         mismatch_cnt = 0;
	bit                  no_gaps = 1'b0;
	int                  deg_root = -1;

	perspective_point_mapper i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.point    (point),
		.done     (done),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #5 clk = ~clk;

	// Whole or fractional constant in Q16.32 bit form
	function automatic logic [COEF_W-1:0] to_q(longint whole, int shift);
		return COEF_W'(whole <<< shift);
	endfunction

	function automatic logic [ACC_W-1:0] sext(logic [COEF_W-1:0] c);
		return {{(ACC_W-COEF_W){c[COEF_W-1]}}, c};
	endfunction

	function automatic longint clamp_quot(logic [ACC_W-1:0] num, logic [ACC_W-1:0] den,
		longint hi);
		longint q;
		if (num == {1'b1, {(ACC_W-1){1'b0}}} && den == '1)
			return hi;
		q = $signed(num) / $signed(den);
		if (q < 0)
			return 0;
		if (q > hi)
			return hi;
		return q;
	endfunction

	function automatic out_item_t map_point(in_item_t p);
		logic [ACC_W-1:0] x, y, nx, ny, den;
		out_item_t        r;
		x   = ACC_W'(p.pix_x);
		y   = ACC_W'(p.pix_y);
		nx  = sext(coef_q[COEF_00]) * x + sext(coef_q[COEF_01]) * y + sext(coef_q[COEF_02]);
		ny  = sext(coef_q[COEF_10]) * x + sext(coef_q[COEF_11]) * y + sext(coef_q[COEF_12]);
		den = sext(coef_q[COEF_20]) * x + sext(coef_q[COEF_21]) * y + ACC_ONE;
		r = '0;
		if (den == '0) begin
			r.degenerate = 1'b1;
		end else begin
			r.room_x = ROOM_X_W'(clamp_quot(nx, den, ROOM_WIDTH_DEF) / 10);
			r.room_y = ROOM_Y_W'(clamp_quot(ny, den, ROOM_LENGTH_DEF) / 10);
		end
		return r;
	endfunction

	// Random coefficient of magnitude below 2^mag_bits, either sign
	function automatic logic [COEF_W-1:0] rand_coef(int unsigned mag_bits);
		logic [63:0] r;
		r = {$urandom, $urandom};
		r = r & ((64'd1 << mag_bits) - 64'd1);
		if ($urandom_range(0, 1))
			r = -r;
		return r[COEF_W-1:0];
	endfunction

	function automatic in_item_t rand_point();
		in_item_t p;
		p.pix_x = PIX_W'($urandom);
		p.pix_y = PIX_W'($urandom);
		if (deg_root >= 0 && $urandom_range(0, 3) == 0)
			p.pix_x = PIX_W'(deg_root);
		return p;
	endfunction

	task automatic send_point(in_item_t p);
		int unsigned gap;
		if ($urandom_range(0, 15) == 0)
			no_gaps = !no_gaps;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		point <= p;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_rooms.insert(pending_rooms.size(), map_point(p));
	endtask

	// Hold off until every request has come back
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_rooms.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic load_matrix();
		for (int i = 0; i < NUM_COEF; i++) begin
			wr_en    <= 1'b1;
			wr_index <= coef_idx_t'(i);
			wr_data  <= staged_coef[i];
			@(posedge clk);
			coef_q[i] = staged_coef[i];
		end
		wr_en <= 1'b0;
	endtask

	task automatic send_xy(int x, int y);
		in_item_t p;
		p.pix_x = PIX_W'(x);
		p.pix_y = PIX_W'(y);
		send_point(p);
	endtask

	task automatic test_identity();
		send_xy(0, 0);
		send_xy(4095, 4095);
		send_xy(4095, 0);
		send_xy(0, 4095);
		send_xy(9, 9);
		send_xy(10, 10);
		send_xy(2730, 1365);
		send_xy(1365, 2730);
	endtask

	task automatic test_room_clamp();
		wait_idle();
		staged_coef = '{default: '0};
		staged_coef[COEF_00] = to_q(2, 32);
		staged_coef[COEF_02] = to_q(-1000, 32);
		staged_coef[COEF_11] = to_q(3, 32);
		staged_coef[COEF_12] = to_q(-100, 32);
		load_matrix();
		send_xy(0, 0);
		send_xy(4095, 4095);
		send_xy(3000, 2533);
		send_xy(504, 34);
		send_xy(509, 60);
	endtask

	// Denominator 1 - x/16 - y/32 is zero on the line 2x + y = 32
	task automatic test_zero_denominator();
		wait_idle();
		staged_coef = '{default: '0};
		staged_coef[COEF_00] = to_q(-100, 32);
		staged_coef[COEF_11] = to_q(1, 32);
		staged_coef[COEF_20] = to_q(-1, 28);
		staged_coef[COEF_21] = to_q(-1, 27);
		load_matrix();
		send_xy(16, 0);
		send_xy(0, 32);
		send_xy(10, 12);
		send_xy(20, 0);
		send_xy(0, 40);
		send_xy(4095, 4095);
	endtask

	task automatic test_coef_extremes();
		wait_idle();
		staged_coef = '{default: {1'b0, {(COEF_W-1){1'b1}}}};
		load_matrix();
		send_xy(0, 0);
		send_xy(4095, 4095);
		wait_idle();
		staged_coef = '{default: {1'b1, {(COEF_W-1){1'b0}}}};
		load_matrix();
		send_xy(0, 0);
		send_xy(4095, 0);
	endtask

	task automatic test_random_matrices();
		int unsigned shift;
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			wait_idle();
			deg_root = -1;
			staged_coef[COEF_00] = rand_coef(34);
			staged_coef[COEF_01] = rand_coef(32);
			staged_coef[COEF_02] = rand_coef(45);
			staged_coef[COEF_10] = rand_coef(32);
			staged_coef[COEF_11] = rand_coef(34);
			staged_coef[COEF_12] = rand_coef(45);
			staged_coef[COEF_20] = rand_coef(20);
			staged_coef[COEF_21] = rand_coef(20);
			case (phase % 4)
				1: begin
					// steep denominator: sign flips inside the image
					staged_coef[COEF_20] = rand_coef(24);
					staged_coef[COEF_21] = rand_coef(24);
				end
				2: begin
					// denominator vanishes at column 2^shift
					shift = $urandom_range(0, PIX_W - 1);
					staged_coef[COEF_20] = to_q(-1, 32 - shift);
					staged_coef[COEF_21] = '0;
					deg_root = 1 << shift;
				end
				3: begin
					for (int i = 0; i < NUM_COEF; i++)
						staged_coef[i] = rand_coef(COEF_W);
				end
				default: ;
			endcase
			load_matrix();
			repeat (PHASE_POINTS)
				send_point(rand_point());
		end
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && done) begin
			if (pending_rooms.size() == 0) begin
				$error("result: none expected, got room_x %0d room_y %0d degenerate %0b",
					result.room_x, result.room_y, result.degenerate);
				mismatch_cnt++;
			end else begin
				want = pending_rooms.pop_front();
				if (result.room_x !== want.room_x) begin
					$error("room_x: expected %0d, got %0d", want.room_x, result.room_x);
					mismatch_cnt++;
				end
				if (result.room_y !== want.room_y) begin
					$error("room_y: expected %0d, got %0d", want.room_y, result.room_y);
					mismatch_cnt++;
				end
				if (result.degenerate !== want.degenerate) begin
					$error("degenerate: expected %0b, got %0b", want.degenerate,
						result.degenerate);
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		coef_q = '{default: '0};
		coef_q[COEF_00] = COEF_ONE;
		coef_q[COEF_11] = COEF_ONE;
		staged_coef = '{default: '0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_identity();
		test_room_clamp();
		test_zero_denominator();
		test_coef_extremes();
		test_random_matrices();

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/ppm_pkg.sv
hw/rtl/ppm_div.sv
hw/rtl/perspective_point_mapper.sv
sim/tb_top.sv
